@@ hdl/tss_pkg.sv @@
// shared types, constants and the arctangent table for the three-sine sweep
// no dependencies; used by tss_mul, tss_cordic and three_sine_sum_sweep
package tss_pkg;

  // rotation steps per sine evaluation
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int ATAN_IDX_W   = 5;

  // 1/(2*pi) in Q0.32 and cordic start vector (gain compensation, Q1.30)
  localparam logic [31:0] INV_TWO_PI_Q32  = 32'd683565276;
  localparam logic [31:0] CORDIC_GAIN_Q30 = 32'h26DD3B6A;

  typedef enum logic [2:0] {
    REG_GAIN_ONE,
    REG_FREQ_ONE,
    REG_GAIN_TWO,
    REG_FREQ_TWO,
    REG_GAIN_THREE,
    REG_FREQ_THREE,
    REG_X_STEP,
    REG_X_END
  } reg_idx_e;

  typedef enum logic {
    KIND_START,
    KIND_ADVANCE
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PHASE,
    ST_TURN,
    ST_FOLD,
    ST_ROT,
    ST_GAIN,
    ST_ACC,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [31:0] op_a;
    logic [31:0] op_b;
  } mul_req_t;

  typedef struct packed {
    logic        start;
    logic [33:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] sine;
  } cordic_rsp_t;

  // atan(2^-i) in 2^32-per-turn units
  function automatic logic [31:0] atan_turn(logic [ATAN_IDX_W-1:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:    val = 32'h20000000;
      5'd1:    val = 32'h12E4051E;
      5'd2:    val = 32'h09FB385B;
      5'd3:    val = 32'h051111D4;
      5'd4:    val = 32'h028B0D43;
      5'd5:    val = 32'h0145D7E1;
      5'd6:    val = 32'h00A2F61E;
      5'd7:    val = 32'h00517C55;
      5'd8:    val = 32'h0028BE53;
      5'd9:    val = 32'h00145F2F;
      5'd10:   val = 32'h000A2F98;
      5'd11:   val = 32'h000517CC;
      5'd12:   val = 32'h00028BE6;
      5'd13:   val = 32'h000145F3;
      5'd14:   val = 32'h0000A2FA;
      5'd15:   val = 32'h0000517D;
      5'd16:   val = 32'h000028BE;
      5'd17:   val = 32'h0000145F;
      5'd18:   val = 32'h00000A30;
      5'd19:   val = 32'h00000518;
      5'd20:   val = 32'h0000028C;
      5'd21:   val = 32'h00000146;
      5'd22:   val = 32'h000000A3;
      5'd23:   val = 32'h00000051;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

@@ hdl/three_sine_sum_sweep.sv @@
// top level of the three-sine sweep: registers, sequencer, output register
// depends on tss_pkg, tss_mul and tss_cordic
// the shared cordic and multiplier serve all three terms, so ready is low while a point
//   runs and a new item is accepted only once the block is back in idle; a stalled
//   result stream holds it in emit
// items that give no result leave the block idle; reset clears sweep state and
//   returns all configuration registers to their defaults
module three_sine_sum_sweep (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] start_x
  input  logic        s_axis_tuser,   // [0] kind
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [15:0] x_value, [41:16] y_value, rest zero
  output logic        m_axis_tlast
);

  // configuration registers
  logic [15:0] gain_q [3];
  logic [15:0] freq_q [3];
  logic [14:0] step_q;
  logic [15:0] end_q;

  // sweep and sequencer state
  tss_pkg::state_e state_q, state_d;
  logic [15:0]        x_q, x_d;
  logic               active_q, active_d;
  logic [1:0]         term_q, term_d;
  logic signed [49:0] acc_q, acc_d;

  // output register
  logic               out_valid_q;
  logic [15:0]        out_x_q;
  logic [25:0]        out_y_q;
  logic               out_last_q;

  // shared units
  tss_pkg::mul_req_t    mul_req;
  logic signed [63:0]   mul_p;
  tss_pkg::cordic_req_t cor_req;
  tss_pkg::cordic_rsp_t cor_rsp;

  // sweep arithmetic
  logic signed [17:0] x_ext, step_ext, end_ext, sx_ext, next_x;
  logic               start_ok, adv_ok, last_calc;
  logic               in_fire, emit_load;
  logic [31:0]        turn, folded;
  logic signed [49:0] acc_rnd;
  logic signed [27:0] y_wide;
  logic [25:0]        y_sat;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == tss_pkg::ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign emit_load     = (state_q == tss_pkg::ST_EMIT) && (!out_valid_q || m_axis_tready);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q[0] <= 16'd256;
      freq_q[0] <= 16'd256;
      gain_q[1] <= 16'd128;
      freq_q[1] <= 16'd512;
      gain_q[2] <= 16'd77;
      freq_q[2] <= 16'd768;
      step_q    <= 15'd26;
      end_q     <= 16'd2560;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (tss_pkg::reg_idx_e'(cfg_index_i))
        tss_pkg::REG_GAIN_ONE:   gain_q[0] <= cfg_data_i;
        tss_pkg::REG_FREQ_ONE:   freq_q[0] <= cfg_data_i;
        tss_pkg::REG_GAIN_TWO:   gain_q[1] <= cfg_data_i;
        tss_pkg::REG_FREQ_TWO:   freq_q[1] <= cfg_data_i;
        tss_pkg::REG_GAIN_THREE: gain_q[2] <= cfg_data_i;
        tss_pkg::REG_FREQ_THREE: freq_q[2] <= cfg_data_i;
        tss_pkg::REG_X_STEP:     step_q    <= cfg_data_i[14:0];
        tss_pkg::REG_X_END:      end_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sweep bounds, 18 bit so that x plus step never wraps
  always_comb begin
    x_ext     = $signed({{2{x_q[15]}}, x_q});
    step_ext  = $signed({3'b000, step_q});
    end_ext   = $signed({{2{end_q[15]}}, end_q});
    sx_ext    = $signed({{2{s_axis_tdata[15]}}, s_axis_tdata});
    next_x    = x_ext + step_ext;
    start_ok  = (step_q != '0) && (sx_ext < end_ext);
    adv_ok    = active_q && (step_q != '0) && (next_x <= end_ext);
    last_calc = next_x > end_ext;
  end

  // phase fold into [-1/4, +1/4] turn
  always_comb begin
    turn   = mul_p[47:16];
    folded = (turn[31:30] == 2'b01 || turn[31:30] == 2'b10) ?
             (32'h80000000 - turn) : turn;
  end

  // round to Q.16 and saturate to 26 bits
  always_comb begin
    acc_rnd = acc_q + 50'sd2097152;
    y_wide  = acc_rnd[49:22];
    if (y_wide > 28'sd33554431) begin
      y_sat = 26'h1FFFFFF;
    end else if (y_wide < -28'sd33554432) begin
      y_sat = 26'h2000000;
    end else begin
      y_sat = y_wide[25:0];
    end
  end

  // sequencer: per term phase multiply, turn multiply, fold, rotate, weight, add; then emit
  always_comb begin
    state_d        = state_q;
    x_d            = x_q;
    active_d       = active_q;
    term_d         = term_q;
    acc_d          = acc_q;
    mul_req.op_a   = '0;
    mul_req.op_b   = '0;
    cor_req.start  = 1'b0;
    cor_req.angle  = {{2{folded[31]}}, folded};
    unique case (state_q)
      tss_pkg::ST_IDLE: begin
        if (in_fire) begin
          term_d = '0;
          acc_d  = '0;
          if (tss_pkg::kind_e'(s_axis_tuser) == tss_pkg::KIND_START) begin
            if (start_ok) begin
              x_d      = s_axis_tdata;
              active_d = 1'b1;
              state_d  = tss_pkg::ST_PHASE;
            end else begin
              active_d = 1'b0;
            end
          end else if (active_q) begin
            if (adv_ok) begin
              x_d     = next_x[15:0];
              state_d = tss_pkg::ST_PHASE;
            end else begin
              active_d = 1'b0;
            end
          end
        end
      end
      tss_pkg::ST_PHASE: begin
        mul_req.op_a = {{16{freq_q[term_q][15]}}, freq_q[term_q]};
        mul_req.op_b = {{16{x_q[15]}}, x_q};
        state_d      = tss_pkg::ST_TURN;
      end
      tss_pkg::ST_TURN: begin
        mul_req.op_a = mul_p[31:0];
        mul_req.op_b = tss_pkg::INV_TWO_PI_Q32;
        state_d      = tss_pkg::ST_FOLD;
      end
      tss_pkg::ST_FOLD: begin
        cor_req.start = 1'b1;
        state_d       = tss_pkg::ST_ROT;
      end
      tss_pkg::ST_ROT: begin
        if (cor_rsp.done) begin
          state_d = tss_pkg::ST_GAIN;
        end
      end
      tss_pkg::ST_GAIN: begin
        mul_req.op_a = {{16{gain_q[term_q][15]}}, gain_q[term_q]};
        mul_req.op_b = cor_rsp.sine;
        state_d      = tss_pkg::ST_ACC;
      end
      tss_pkg::ST_ACC: begin
        acc_d = acc_q + $signed({{2{mul_p[47]}}, mul_p[47:0]});
        if (term_q == 2'd2) begin
          state_d = tss_pkg::ST_EMIT;
        end else begin
          term_d  = term_q + 1'b1;
          state_d = tss_pkg::ST_PHASE;
        end
      end
      tss_pkg::ST_EMIT: begin
        // hold until the output register is free
        if (emit_load) begin
          active_d = !last_calc;
          state_d  = tss_pkg::ST_IDLE;
        end
      end
      default: state_d = tss_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= tss_pkg::ST_IDLE;
      x_q      <= '0;
      active_q <= 1'b0;
      term_q   <= '0;
    end else begin
      state_q  <= state_d;
      x_q      <= x_d;
      active_q <= active_d;
      term_q   <= term_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // output register, parts the sequencer from the result stream
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      out_x_q    <= x_q;
      out_y_q    <= y_sat;
      out_last_q <= last_calc;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b000000, out_y_q, out_x_q};
  assign m_axis_tlast  = out_last_q;

  tss_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (mul_p)
  );

  tss_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cor_req),
    .rsp_o  (cor_rsp)
  );

`ifndef SYNTHESIS
  // the cordic only finishes while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cor_rsp.done |-> state_q == tss_pkg::ST_ROT)
    else $error("cordic done outside rotate state");

  // a new result only appears from the emit state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == tss_pkg::ST_EMIT)
    else $error("result valid without emit");

  // the final point of a sweep leaves the block idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_load && last_calc) |=> !active_q)
    else $error("sweep still active after last point");
`endif

endmodule

@@ hdl/tss_mul.sv @@
// shared signed 32x32 multiplier with registered product
// depends on tss_pkg for the operand struct
module tss_mul (
  input  logic               clk_i,
  input  tss_pkg::mul_req_t  req_i,
  output logic signed [63:0] prod_o
);

  logic signed [63:0] prod_q;
  logic signed [63:0] prod_d;

  assign prod_d = $signed(req_i.op_a) * $signed(req_i.op_b);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

@@ hdl/tss_cordic.sv @@
// iterative rotation-mode cordic, one micro-rotation per cycle
// depends on tss_pkg for step count, start vector and angle table
module tss_cordic (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tss_pkg::cordic_req_t  req_i,
  output tss_pkg::cordic_rsp_t  rsp_o
);

  logic signed [32:0] cx_q, cx_d;
  logic signed [32:0] cy_q, cy_d;
  logic signed [33:0] z_q, z_d;
  logic [tss_pkg::STEP_W-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic done_q, done_d;

  logic signed [32:0] dx, dy;
  logic signed [33:0] atan_val;
  logic               last_step;

  always_comb begin
    dx        = cy_q >>> cnt_q;
    dy        = cx_q >>> cnt_q;
    atan_val  = $signed({2'b00,
                tss_pkg::atan_turn(tss_pkg::ATAN_IDX_W'(cnt_q))});
    last_step = (cnt_q == tss_pkg::STEP_W'(tss_pkg::CORDIC_STEPS - 1));
    cx_d   = cx_q;
    cy_d   = cy_q;
    z_d    = z_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      cx_d   = $signed({1'b0, tss_pkg::CORDIC_GAIN_Q30});
      cy_d   = '0;
      z_d    = $signed(req_i.angle);
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // rotate towards zero residual angle
      if (!z_q[33]) begin
        cx_d = cx_q - dx;
        cy_d = cy_q + dy;
        z_d  = z_q - atan_val;
      end else begin
        cx_d = cx_q + dx;
        cy_d = cy_q - dy;
        z_d  = z_q + atan_val;
      end
      cnt_d = cnt_q + 1'b1;
      if (last_step) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q <= cx_d;
    cy_q <= cy_d;
    z_q  <= z_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.sine = cy_q[31:0];

endmodule

@@ verif/tb_three_sine_sum_sweep.sv @@
// self-checking testbench for three_sine_sum_sweep: directed and random sweeps
// with its own fixed-point predictor; depends on tss_pkg and the block's rtl
`timescale 1ns / 1ps

module tb_three_sine_sum_sweep;
  import tss_pkg::*;

  // cycles from an accepted transaction to its point, plus a little margin
  localparam int SETTLE_CYCLES = 3 * (CORDIC_STEPS + 6) + 1 + 4;
  // minimum items per random batch; every batch gets a fresh register set
  localparam int BATCH_ITEMS   = 60;
  localparam int BATCHES       = 6;

  // 1/(2*pi) in Q0.32 and the cordic start vector in Q1.30
  localparam longint TURN_SCALE = 64'sd683565276;
  localparam longint ROT_INIT   = 64'sh26DD3B6A;
  localparam int     ARC_LEN    = 24;

  // atan(2^-i), 2^32 per turn
  localparam longint ARC_TURNS [ARC_LEN] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
    64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  typedef struct {
    kind_e       kind;
    logic [15:0] start_x;
  } sweep_item_t;

  typedef struct {
    logic [15:0] x_value;
    logic [25:0] y_value;
    logic        last_point;
  } sweep_point_t;

  typedef struct {
    reg_idx_e    idx;
    logic [15:0] data;
  } reg_write_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_valid_i    = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i    = '0;
  logic [15:0] cfg_data_i     = '0;
  logic        s_axis_tvalid  = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata   = '0;   // [15:0] start_x
  logic        s_axis_tuser   = 1'b0; // [0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready  = 1'b0;
  logic [47:0] m_axis_tdata;          // [15:0] x_value, [41:16] y_value, [47:42] zero
  logic        m_axis_tlast;

  three_sine_sum_sweep dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor state: a copy of the registers and of the sweep position,
  // starting from the block's reset values
  // ---------------------------------------------------------------------------
  logic signed [15:0] gain_r [3] = '{16'sd256, 16'sd128, 16'sd77};
  logic signed [15:0] freq_r [3] = '{16'sd256, 16'sd512, 16'sd768};
  logic        [14:0] x_step_r   = 15'd26;
  logic signed [15:0] x_end_r    = 16'sd2560;
  longint             sweep_x    = 0;
  logic               sweep_on   = 1'b0;

  sweep_item_t  stim_q  [$];   // items waiting for the driver
  sweep_point_t point_q [$];   // points still owed by the block
  reg_write_t   cfg_q   [$];   // register writes for the next idle window
  sweep_item_t  cur_item;
  int           send_idle_pct  = 0;
  int           recv_idle_pct  = 0;
  int           mismatch_count = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // sine of a Q16.16 radian phase, in Q1.30: turn reduction, fold to the
  // right half plane, then rotation-mode cordic with floor shifts
  function automatic longint sine_of_phase(input longint phase);
    logic signed [63:0] prod;
    logic        [31:0] turn;
    logic        [31:0] folded;
    longint             ang;
    longint             cx;
    longint             cy;
    longint             dx;
    longint             dy;
    prod   = phase * TURN_SCALE;
    turn   = prod[47:16];
    folded = (turn[31:30] == 2'b01 || turn[31:30] == 2'b10) ? 32'h80000000 - turn : turn;
    ang    = longint'($signed(folded));
    cx     = ROT_INIT;
    cy     = 0;
    for (int i = 0; i < CORDIC_STEPS && i < ARC_LEN; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (ang >= 0) begin
        cx  -= dx;
        cy  += dy;
        ang -= ARC_TURNS[i];
      end else begin
        cx  += dx;
        cy  -= dy;
        ang += ARC_TURNS[i];
      end
    end
    return cy;
  endfunction

  // weighted sum of the three sines at x, rounded to Q.16 and saturated
  function automatic logic [25:0] sweep_y(input longint xq);
    longint acc;
    acc = 0;
    for (int k = 0; k < 3; k++)
      acc += longint'(gain_r[k]) * sine_of_phase(longint'(freq_r[k]) * xq);
    acc = (acc + 64'sd2097152) >>> 22;
    if (acc > 64'sd33554431)  acc = 64'sd33554431;
    if (acc < -64'sd33554432) acc = -64'sd33554432;
    return acc[25:0];
  endfunction

  function automatic void owe_point();
    sweep_point_t p;
    p.x_value    = sweep_x[15:0];
    p.y_value    = sweep_y(sweep_x);
    p.last_point = (sweep_x + longint'(x_step_r)) > longint'(x_end_r);
    point_q.push_back(p);
    if (p.last_point) sweep_on = 1'b0;
  endfunction

  // called once per accepted input transaction
  function automatic void predict_item(input sweep_item_t it);
    longint stepv;
    longint endv;
    stepv = longint'(x_step_r);
    endv  = longint'(x_end_r);
    if (it.kind == KIND_START) begin
      // start at or past the end, or with a zero step: nothing, idle
      if (stepv == 0 || longint'($signed(it.start_x)) >= endv) begin
        sweep_on = 1'b0;
        return;
      end
      sweep_x  = longint'($signed(it.start_x));
      sweep_on = 1'b1;
      owe_point();
    end else begin
      if (!sweep_on) return;
      // zero step, or the end moved below the next point: sweep ends silently
      if (stepv == 0 || sweep_x + stepv > endv) begin
        sweep_on = 1'b0;
        return;
      end
      sweep_x += stepv;
      owe_point();
    end
  endfunction

  function automatic void apply_reg(input reg_idx_e idx, input logic [15:0] d);
    case (idx)
      REG_GAIN_ONE:   gain_r[0] = d;
      REG_FREQ_ONE:   freq_r[0] = d;
      REG_GAIN_TWO:   gain_r[1] = d;
      REG_FREQ_TWO:   freq_r[1] = d;
      REG_GAIN_THREE: gain_r[2] = d;
      REG_FREQ_THREE: freq_r[2] = d;
      REG_X_STEP:     x_step_r  = d[14:0];
      REG_X_END:      x_end_r   = d;
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // driver: presents queued items, idling at random; the item is handed to
  // the predictor at the edge where the transaction completes
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_item(cur_item);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (stim_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_item = stim_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= cur_item.start_x;
          s_axis_tuser  <= cur_item.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random back-pressure, each point checked against the oldest one owed
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (point_q.size() == 0) begin
          report_mismatch($sformatf("unexpected point x=%0d", $signed(m_axis_tdata[15:0])));
        end else begin
          sweep_point_t p;
          p = point_q.pop_front();
          if (m_axis_tdata[15:0] !== p.x_value)
            report_mismatch($sformatf("x_value got %0d want %0d",
                                      $signed(m_axis_tdata[15:0]), $signed(p.x_value)));
          if (m_axis_tdata[41:16] !== p.y_value)
            report_mismatch($sformatf("y_value at x=%0d got %0d want %0d",
                                      $signed(p.x_value), $signed(m_axis_tdata[41:16]),
                                      $signed(p.y_value)));
          if (m_axis_tlast !== p.last_point)
            report_mismatch($sformatf("last_point at x=%0d got %b want %b",
                                      $signed(p.x_value), m_axis_tlast, p.last_point));
          if (m_axis_tdata[47:42] !== 6'd0)
            report_mismatch($sformatf("tdata padding got %b", m_axis_tdata[47:42]));
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_item(input kind_e k, input logic [15:0] sx);
    sweep_item_t it;
    it.kind    = k;
    it.start_x = sx;
    stim_q.push_back(it);
  endtask

  task automatic queue_reg(input reg_idx_e idx, input logic [15:0] d);
    reg_write_t w;
    w.idx  = idx;
    w.data = d;
    cfg_q.push_back(w);
  endtask

  // sender held off until the block has delivered every point and gone quiet
  task automatic wait_quiet();
    do @(negedge clk_i);
    while (stim_q.size() != 0 || s_axis_tvalid || point_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // called at a rising edge; valid stays high across back-to-back writes
  task automatic program_regs();
    reg_write_t w;
    while (cfg_q.size() != 0) begin
      w = cfg_q.pop_front();
      cfg_valid_i <= 1'b1;
      cfg_index_i <= w.idx;
      cfg_data_i  <= w.data;
      do @(posedge clk_i);
      while (!cfg_ready_o);
      apply_reg(w.idx, w.data);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Q8.8 value with a bias towards the extremes and zero
  function automatic logic [15:0] pick_q88();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic queue_random_regs();
    int stepv;
    stepv = $urandom_range(1, 1 << $urandom_range(0, 15));
    if (stepv > 32767) stepv = 32767;
    queue_reg(REG_GAIN_ONE,   pick_q88());
    queue_reg(REG_FREQ_ONE,   pick_q88());
    queue_reg(REG_GAIN_TWO,   pick_q88());
    queue_reg(REG_FREQ_TWO,   pick_q88());
    queue_reg(REG_GAIN_THREE, pick_q88());
    queue_reg(REG_FREQ_THREE, pick_q88());
    // bit 15 is not part of the step register but is toggled anyway
    queue_reg(REG_X_STEP,     {1'($urandom_range(1)), 15'(stepv)});
    queue_reg(REG_X_END,      pick_q88());
  endtask

  // mostly whole sweeps aimed to land near the end value, some cut short
  // (restart mid-sweep), the rest loose items of either kind
  task automatic queue_random_sweeps(input int n);
    int     made;
    int     r;
    int     pts;
    int     adv;
    int     stepi;
    longint sx;
    made  = 0;
    stepi = int'(x_step_r);
    while (made < n) begin
      r = $urandom_range(99);
      if (r < 85) begin
        pts = $urandom_range(0, 12);
        sx  = longint'(x_end_r) - longint'(stepi) * pts;
        if (stepi > 1) sx -= $urandom_range(0, stepi - 1);
        if (sx < -32768) sx = -32768;
        push_item(KIND_START, sx[15:0]);
        adv = (r < 70) ? pts + $urandom_range(0, 2) : $urandom_range(0, pts);
        repeat (adv) push_item(KIND_ADVANCE, 16'($urandom_range(65535)));
        made += 1 + adv;
      end else begin
        push_item(kind_e'($urandom_range(1)), 16'($urandom_range(65535)));
        made++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 27;
    recv_idle_pct = 50;
    @(negedge clk_i);

    // reset defaults: step 26, end 2560
    push_item(KIND_ADVANCE, 16'h0000);    // advance while idle
    push_item(KIND_START,   16'd2500);
    push_item(KIND_ADVANCE, 16'hFFFF);
    push_item(KIND_ADVANCE, 16'h0000);    // final point of the sweep
    push_item(KIND_ADVANCE, 16'h0000);    // sweep over, ignored
    push_item(KIND_START,   16'd2560);    // start exactly at the end
    push_item(KIND_START,   16'h7FFF);    // start beyond the end
    push_item(KIND_START,   16'h8000);
    push_item(KIND_START,   16'h0000);    // restart in the middle of a sweep
    push_item(KIND_ADVANCE, 16'h5A5A);
    wait_quiet();

    // extreme registers, widest sweep
    queue_reg(REG_GAIN_ONE,   16'h7FFF);
    queue_reg(REG_FREQ_ONE,   16'h8000);
    queue_reg(REG_GAIN_TWO,   16'h8000);
    queue_reg(REG_FREQ_TWO,   16'h7FFF);
    queue_reg(REG_GAIN_THREE, 16'h7FFF);
    queue_reg(REG_FREQ_THREE, 16'h0001);
    queue_reg(REG_X_STEP,     16'hFFFF);
    queue_reg(REG_X_END,      16'h7FFF);
    program_regs();
    @(negedge clk_i);
    push_item(KIND_START,   16'h8000);
    push_item(KIND_ADVANCE, 16'h0000);
    push_item(KIND_ADVANCE, 16'h0000);
    push_item(KIND_START,   16'h7FFE);    // single point, last at once
    push_item(KIND_START,   16'h0000);    // leaves a sweep running
    wait_quiet();

    // zero step: ends the running sweep, then blocks a new start
    queue_reg(REG_X_STEP, 16'h8000);
    program_regs();
    @(negedge clk_i);
    push_item(KIND_ADVANCE, 16'h0000);
    push_item(KIND_START,   16'h0005);
    wait_quiet();

    queue_reg(REG_X_STEP, 16'h0001);
    queue_reg(REG_X_END,  16'h8001);
    program_regs();
    @(negedge clk_i);
    push_item(KIND_START, 16'h8000);
    wait_quiet();

    // end moved below the next point while a sweep is running
    queue_reg(REG_X_END, 16'h8000);
    program_regs();
    @(negedge clk_i);
    push_item(KIND_ADVANCE, 16'h0000);
    push_item(KIND_ADVANCE, 16'h0000);
    push_item(KIND_START,   16'h8000);
    wait_quiet();

    // random part in three idling profiles
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 50 : 0;
      recv_idle_pct = (ph == 0) ? 50 : (ph == 1) ? 27 : 0;
      for (int b = 0; b < BATCHES; b++) begin
        queue_random_regs();
        program_regs();
        @(negedge clk_i);
        queue_random_sweeps(BATCH_ITEMS);
        wait_quiet();
      end
    end

    if (point_q.size() != 0)
      report_mismatch($sformatf("%0d points never delivered", point_q.size()));
    if (mismatch_count == 0) begin
      $display("three_sine_sum_sweep regression: pass");
    end else begin
      $display("three_sine_sum_sweep regression: fail");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(10_000_000);
    $display("three_sine_sum_sweep regression: fail");
    $finish;
  end

endmodule
